// ===== hw/rtl/ldu_pkg.sv =====
// Shared constants, types and a helper function of the LDU to CSR pattern builder.
package ldu_pkg;

    localparam int MAX_ROWS_DEF  = 256;
    localparam int MAX_FACES_DEF = 1024;

    localparam int CFG_W    = 9;
    localparam int CMD_W    = 2;
    localparam int CELL_W   = 8;
    localparam int IDX_W    = 12;
    localparam int ORD_W    = 12;
    localparam int ST_W     = 2;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD       = 2'd0,
        CMD_BUILD      = 2'd1,
        CMD_READ_ENTRY = 2'd2,
        CMD_READ_ROW   = 2'd3
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_BUILT = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RET_FACES,
        RET_SECOND,
        RET_NEXT
    } t_ret;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_CLR,
        S_CNT_RF,
        S_CNT_FD,
        S_CNT_U,
        S_CNT_LR,
        S_CNT_L,
        S_PTR_RD,
        S_PTR_WR,
        S_PL_COL,
        S_PL_RD,
        S_PL_WR,
        S_PL_RF,
        S_PL_FD,
        S_PL_SECOND
    } t_state;

    function automatic int clog2p(input int depth);
        clog2p = (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// ===== hw/rtl/ldu_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module ldu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = ldu_pkg::clog2p(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ldu_to_csr_pattern_builder_top.sv =====
// Top level of the LDU to CSR pattern builder: command decode, build sequencer and stores.
//
// The block keeps a face list in a face memory and converts it on a build request
// into a CSR pattern held in an entry memory and a row pointer memory. A face load
// gives its result in the cycle after it is accepted; an entry read or a row pointer
// read of a built pattern that is in range gives it through the registered memory read
// and the S_READ state. A new request is accepted only in the idle state while the result
// register is empty or its result is taken in the same cycle. A build request walks the
// memories through one shared count memory with one read-modify-write at a time: it sets
// each row count to one for the diagonal, counts the faces, forms the row pointers and
// then places the diagonal and face entries. Placement scans the face memory once per
// column, which yields rows sorted by column with ties in ordinal order.
module ldu_to_csr_pattern_builder_top #(
    parameter int MAX_ROWS  = ldu_pkg::MAX_ROWS_DEF,
    parameter int MAX_FACES = ldu_pkg::MAX_FACES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ldu_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // upper_cell [7:0], lower_cell [15:8], read_index [27:16], zero fill
    input  logic [ldu_pkg::S_DATA_W-1:0] i_s_tdata,
    // cmd [1:0]
    input  logic [ldu_pkg::CMD_W-1:0]    i_s_tuser,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // entry_column [7:0], entry_ordinal [19:8], row_start [31:20],
    // nonzero_count [43:32], status [45:44], zero fill
    output logic [ldu_pkg::M_DATA_W-1:0] o_m_tdata
);

    import ldu_pkg::*;

    localparam int ED    = MAX_ROWS + 2 * MAX_FACES;
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int FCW   = $clog2(MAX_FACES + 1);
    localparam int PW    = $clog2(ED + 1);
    localparam int FAW   = clog2p(MAX_FACES);
    localparam int EAW   = clog2p(ED);
    localparam int RPAW  = clog2p(MAX_ROWS + 1);
    localparam int CAW   = clog2p(MAX_ROWS);
    localparam int FW    = 2 * CELL_W;
    localparam int EW    = ORD_W + CELL_W;

    t_state             r_state, n_state;
    logic               r_out_valid, n_out_valid;
    logic [CELL_W-1:0]  r_col, n_col;
    logic [ORD_W-1:0]   r_ord, n_ord;
    logic [ORD_W-1:0]   r_rs, n_rs;
    logic [ORD_W-1:0]   r_nzc, n_nzc;
    t_status            r_st, n_st;
    logic [CFG_W-1:0]   r_num_rows, n_num_rows;
    logic [FCW-1:0]     r_face_count, n_face_count;
    logic               r_built, n_built;
    logic [PW-1:0]      r_total, n_total;
    logic [RW-1:0]      r_r, n_r;
    logic [FCW-1:0]     r_fi, n_fi;
    logic [PW-1:0]      r_acc, n_acc;
    logic [CELL_W-1:0]  r_u, n_u;
    logic [CELL_W-1:0]  r_l, n_l;
    logic [RW-1:0]      r_prow, n_prow;
    logic [ORD_W-1:0]   r_pord, n_pord;
    t_ret               r_ret, n_ret;
    logic               r_kind, n_kind;

    logic               w_acc_in;
    t_cmd               w_cmd;
    logic [CELL_W-1:0]  w_up, w_lo;
    logic [IDX_W-1:0]   w_idx;
    logic [RW-1:0]      w_rows;
    logic               w_full;
    logic [CELL_W-1:0]  w_fu, w_fl;
    logic               w_face_ok;
    logic [ORD_W-1:0]   w_ord1, w_ord2;

    logic               face_we, face_re;
    logic [FAW-1:0]     face_waddr, face_raddr;
    logic [FW-1:0]      face_wdata, face_q;
    logic               ent_we, ent_re;
    logic [EAW-1:0]     ent_waddr, ent_raddr;
    logic [EW-1:0]      ent_wdata, ent_q;
    logic               rp_we, rp_re;
    logic [RPAW-1:0]    rp_waddr, rp_raddr;
    logic [PW-1:0]      rp_wdata, rp_q;
    logic               cnt_we, cnt_re;
    logic [CAW-1:0]     cnt_waddr, cnt_raddr;
    logic [PW-1:0]      cnt_wdata, cnt_q;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_s_tready  = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign w_acc_in    = i_s_tvalid && o_s_tready;
    assign w_cmd       = t_cmd'(i_s_tuser);
    assign w_up        = i_s_tdata[7:0];
    assign w_lo        = i_s_tdata[15:8];
    assign w_idx       = i_s_tdata[27:16];
    assign w_rows      = (32'(r_num_rows) > 32'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(r_num_rows);
    assign w_full      = (32'(r_face_count) == 32'(MAX_FACES));
    assign w_fu        = face_q[FW-1:CELL_W];
    assign w_fl        = face_q[CELL_W-1:0];
    assign w_face_ok   = (32'(w_fu) < 32'(w_rows)) && (32'(w_fl) < 32'(w_rows));
    assign w_ord1      = ORD_W'(32'(w_rows) + 2 * 32'(r_fi) + 1);
    assign w_ord2      = ORD_W'(32'(w_rows) + 2 * 32'(r_fi) + 2);

    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {2'b00, r_st, r_nzc, r_rs, r_ord, r_col};

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_col        = r_col;
        n_ord        = r_ord;
        n_rs         = r_rs;
        n_nzc        = r_nzc;
        n_st         = r_st;
        n_num_rows   = r_num_rows;
        n_face_count = r_face_count;
        n_built      = r_built;
        n_total      = r_total;
        n_r          = r_r;
        n_fi         = r_fi;
        n_acc        = r_acc;
        n_u          = r_u;
        n_l          = r_l;
        n_prow       = r_prow;
        n_pord       = r_pord;
        n_ret        = r_ret;
        n_kind       = r_kind;
        if (i_cfg_valid && o_cfg_ready) begin
            n_num_rows = i_cfg_data;
            n_built    = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_acc_in) begin
                    n_col = '0;
                    n_ord = '0;
                    n_rs  = '0;
                    n_st  = ST_OK;
                    n_nzc = r_built ? ORD_W'(r_total) : '0;
                    unique case (w_cmd)
                        CMD_LOAD: begin
                            n_out_valid = 1'b1;
                            if (w_full) begin
                                n_st = ST_OVERFLOW;
                            end else begin
                                n_face_count = r_face_count + 1'b1;
                                n_built      = 1'b0;
                                n_nzc        = '0;
                            end
                        end
                        CMD_BUILD: begin
                            n_state = S_CLR;
                            n_r     = '0;
                        end
                        CMD_READ_ENTRY, CMD_READ_ROW: begin
                            if (!r_built) begin
                                n_out_valid = 1'b1;
                                n_st        = ST_NOT_BUILT;
                            end else if ((w_cmd == CMD_READ_ENTRY)
                                         ? (32'(w_idx) >= 32'(r_total))
                                         : (32'(w_idx) > 32'(w_rows))) begin
                                n_out_valid = 1'b1;
                                n_st        = ST_RANGE;
                            end else begin
                                n_state = S_READ;
                                n_kind  = (w_cmd == CMD_READ_ENTRY);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                n_out_valid = 1'b1;
                n_col       = r_kind ? ent_q[CELL_W-1:0] : '0;
                n_ord       = r_kind ? ent_q[EW-1:CELL_W] : '0;
                n_rs        = r_kind ? '0 : ORD_W'(rp_q);
                n_nzc       = ORD_W'(r_total);
                n_st        = ST_OK;
                n_state     = S_IDLE;
            end
            S_CLR: begin
                if (r_r == w_rows) begin
                    n_state = S_CNT_RF;
                    n_fi    = '0;
                end else begin
                    n_r = r_r + 1'b1;
                end
            end
            S_CNT_RF: begin
                if (r_fi == r_face_count) begin
                    n_state = S_PTR_RD;
                    n_r     = '0;
                    n_acc   = '0;
                end else begin
                    n_state = S_CNT_FD;
                end
            end
            S_CNT_FD: begin
                n_u = w_fu;
                n_l = w_fl;
                if (w_face_ok) begin
                    n_state = S_CNT_U;
                end else begin
                    n_fi    = r_fi + 1'b1;
                    n_state = S_CNT_RF;
                end
            end
            S_CNT_U: begin
                n_state = S_CNT_LR;
            end
            S_CNT_LR: begin
                n_state = S_CNT_L;
            end
            S_CNT_L: begin
                n_fi    = r_fi + 1'b1;
                n_state = S_CNT_RF;
            end
            S_PTR_RD: begin
                if (r_r == w_rows) begin
                    n_total = r_acc;
                    n_r     = '0;
                    n_state = S_PL_COL;
                end else begin
                    n_state = S_PTR_WR;
                end
            end
            S_PTR_WR: begin
                n_acc   = r_acc + cnt_q;
                n_r     = r_r + 1'b1;
                n_state = S_PTR_RD;
            end
            S_PL_COL: begin
                if (r_r == w_rows) begin
                    n_built     = 1'b1;
                    n_out_valid = 1'b1;
                    n_col       = '0;
                    n_ord       = '0;
                    n_rs        = '0;
                    n_nzc       = ORD_W'(r_total);
                    n_st        = ST_OK;
                    n_state     = S_IDLE;
                end else begin
                    n_prow  = r_r;
                    n_pord  = ORD_W'(32'(r_r) + 1);
                    n_ret   = RET_FACES;
                    n_state = S_PL_RD;
                end
            end
            S_PL_RD: begin
                n_state = S_PL_WR;
            end
            S_PL_WR: begin
                case (r_ret)
                    RET_FACES: begin
                        n_fi    = '0;
                        n_state = S_PL_RF;
                    end
                    RET_SECOND: begin
                        n_state = S_PL_SECOND;
                    end
                    default: begin
                        n_fi    = r_fi + 1'b1;
                        n_state = S_PL_RF;
                    end
                endcase
            end
            S_PL_RF: begin
                if (r_fi == r_face_count) begin
                    n_r     = r_r + 1'b1;
                    n_state = S_PL_COL;
                end else begin
                    n_state = S_PL_FD;
                end
            end
            S_PL_FD: begin
                n_u = w_fu;
                n_l = w_fl;
                if (w_face_ok && (32'(w_fl) == 32'(r_r))) begin
                    n_prow  = RW'(w_fu);
                    n_pord  = w_ord1;
                    n_ret   = RET_SECOND;
                    n_state = S_PL_RD;
                end else if (w_face_ok && (32'(w_fu) == 32'(r_r))) begin
                    n_prow  = RW'(w_fl);
                    n_pord  = w_ord2;
                    n_ret   = RET_NEXT;
                    n_state = S_PL_RD;
                end else begin
                    n_fi    = r_fi + 1'b1;
                    n_state = S_PL_RF;
                end
            end
            S_PL_SECOND: begin
                if (32'(r_u) == 32'(r_r)) begin
                    n_prow  = RW'(r_l);
                    n_pord  = w_ord2;
                    n_ret   = RET_NEXT;
                    n_state = S_PL_RD;
                end else begin
                    n_fi    = r_fi + 1'b1;
                    n_state = S_PL_RF;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        face_we    = (r_state == S_IDLE) && w_acc_in && (w_cmd == CMD_LOAD) && !w_full;
        face_waddr = r_face_count[FAW-1:0];
        face_wdata = {w_up, w_lo};
        face_re    = ((r_state == S_CNT_RF) || (r_state == S_PL_RF)) && (r_fi != r_face_count);
        face_raddr = r_fi[FAW-1:0];

        ent_we    = (r_state == S_PL_WR);
        ent_waddr = cnt_q[EAW-1:0];
        ent_wdata = {r_pord, CELL_W'(r_r)};
        ent_re    = (r_state == S_IDLE) && w_acc_in && (w_cmd == CMD_READ_ENTRY);
        ent_raddr = EAW'(w_idx);

        rp_we    = 1'b0;
        rp_waddr = '0;
        rp_wdata = '0;
        if (r_state == S_PTR_WR) begin
            rp_we    = 1'b1;
            rp_waddr = RPAW'(r_r + 1'b1);
            rp_wdata = r_acc + cnt_q;
        end else if ((r_state == S_CNT_RF) && (r_fi == r_face_count)) begin
            rp_we = 1'b1;
        end
        rp_re    = (r_state == S_IDLE) && w_acc_in && (w_cmd == CMD_READ_ROW);
        rp_raddr = RPAW'(w_idx);

        cnt_we    = 1'b0;
        cnt_waddr = '0;
        cnt_wdata = '0;
        cnt_re    = 1'b0;
        cnt_raddr = '0;
        unique case (r_state)
            S_CLR: begin
                cnt_we    = (r_r != w_rows);
                cnt_waddr = r_r[CAW-1:0];
                cnt_wdata = PW'(1);
            end
            S_CNT_FD: begin
                cnt_re    = w_face_ok;
                cnt_raddr = CAW'(w_fu);
            end
            S_CNT_U: begin
                cnt_we    = 1'b1;
                cnt_waddr = CAW'(r_u);
                cnt_wdata = cnt_q + 1'b1;
            end
            S_CNT_LR: begin
                cnt_re    = 1'b1;
                cnt_raddr = CAW'(r_l);
            end
            S_CNT_L: begin
                cnt_we    = 1'b1;
                cnt_waddr = CAW'(r_l);
                cnt_wdata = cnt_q + 1'b1;
            end
            S_PTR_RD: begin
                cnt_re    = (r_r != w_rows);
                cnt_raddr = r_r[CAW-1:0];
            end
            S_PTR_WR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_r[CAW-1:0];
                cnt_wdata = r_acc;
            end
            S_PL_RD: begin
                cnt_re    = 1'b1;
                cnt_raddr = r_prow[CAW-1:0];
            end
            S_PL_WR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_prow[CAW-1:0];
                cnt_wdata = cnt_q + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_num_rows   <= CFG_W'(1);
            r_face_count <= '0;
            r_built      <= 1'b0;
            r_total      <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_num_rows   <= n_num_rows;
            r_face_count <= n_face_count;
            r_built      <= n_built;
            r_total      <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col  <= n_col;
        r_ord  <= n_ord;
        r_rs   <= n_rs;
        r_nzc  <= n_nzc;
        r_st   <= n_st;
        r_r    <= n_r;
        r_fi   <= n_fi;
        r_acc  <= n_acc;
        r_u    <= n_u;
        r_l    <= n_l;
        r_prow <= n_prow;
        r_pord <= n_pord;
        r_ret  <= n_ret;
        r_kind <= n_kind;
    end

    ldu_ram #(.WIDTH(FW), .DEPTH(MAX_FACES), .AW(FAW)) u_face_ram (
        .i_clk   (i_clk),
        .i_we    (face_we),
        .i_waddr (face_waddr),
        .i_wdata (face_wdata),
        .i_re    (face_re),
        .i_raddr (face_raddr),
        .o_rdata (face_q)
    );

    ldu_ram #(.WIDTH(EW), .DEPTH(ED), .AW(EAW)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (ent_q)
    );

    ldu_ram #(.WIDTH(PW), .DEPTH(MAX_ROWS + 1), .AW(RPAW)) u_rowptr_ram (
        .i_clk   (i_clk),
        .i_we    (rp_we),
        .i_waddr (rp_waddr),
        .i_wdata (rp_wdata),
        .i_re    (rp_re),
        .i_raddr (rp_raddr),
        .o_rdata (rp_q)
    );

    ldu_ram #(.WIDTH(PW), .DEPTH(MAX_ROWS), .AW(CAW)) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_q)
    );

endmodule

// ===== tb/sv/ldu_to_csr_pattern_builder_top_tb.sv =====
// Self-checking testbench of the LDU to CSR pattern builder: face loads, builds and read-backs.
module ldu_to_csr_pattern_builder_top_tb;
    import ldu_pkg::*;

    localparam int N_MAX = 256;
    localparam int F_MAX = 1024;
    localparam int E_MAX = N_MAX + 2 * F_MAX;

    typedef struct {
        t_cmd       cmd;
        logic [7:0] up;
        logic [7:0] lo;
        logic [11:0] idx;
    } t_req;

    typedef struct {
        logic [7:0]  col;
        logic [11:0] ord;
        logic [11:0] rs;
        logic [11:0] nnz;
        t_status     st;
    } t_rsp;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_data = '0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata = '0;
    logic [CMD_W-1:0]    i_s_tuser = '0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;

    ldu_to_csr_pattern_builder_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    t_req pend_q[$];
    t_rsp csr_expect_q[$];
    bit   failed = 0;
    bit   s_fire = 0;
    int   cfg_writes = 0;
    bit   hold_req = 0;
    int   cfgs[9] = '{256, 511, 12, 5, 32, 1, 0, 20, 3};

    // Shadow copy of the block state.
    logic [7:0]  face_up[F_MAX];
    logic [7:0]  face_lo[F_MAX];
    int          face_cnt = 0;
    logic [7:0]  ent_col[E_MAX];
    logic [11:0] ent_ord[E_MAX];
    int          row_ptr[N_MAX + 1];
    int          fill[N_MAX];
    bit          is_built = 0;
    int          row_cfg = 1;
    int          ent_total = 0;

    function automatic int rows_eff();
        return (row_cfg > N_MAX) ? N_MAX : row_cfg;
    endfunction

    function automatic void place(int r, int c, int o);
        int p;
        p = fill[r];
        if (p < E_MAX) begin
            ent_col[p] = 8'(c);
            ent_ord[p] = 12'(o);
        end
        fill[r] = p + 1;
    endfunction

    function automatic void build_csr();
        int n, lo_p, hi_p, b, c, o, u, l;
        n = rows_eff();
        for (int r = 0; r < n; r++) fill[r] = 1;
        for (int i = 0; i < face_cnt; i++) begin
            u = int'(face_up[i]);
            l = int'(face_lo[i]);
            if (u < n && l < n) begin
                fill[u]++;
                fill[l]++;
            end
        end
        row_ptr[0] = 0;
        for (int r = 0; r < n; r++) begin
            row_ptr[r + 1] = row_ptr[r] + fill[r];
            fill[r] = row_ptr[r];
        end
        ent_total = row_ptr[n];
        for (int r = 0; r < n; r++) place(r, r, r + 1);
        for (int i = 0; i < face_cnt; i++) begin
            u = int'(face_up[i]);
            l = int'(face_lo[i]);
            if (u < n && l < n) begin
                place(u, l, n + 2 * i + 1);
                place(l, u, n + 2 * i + 2);
            end
        end
        for (int r = 0; r < n; r++) begin
            lo_p = row_ptr[r];
            hi_p = row_ptr[r + 1];
            for (int a = lo_p + 1; a < hi_p; a++) begin
                c = int'(ent_col[a]);
                o = int'(ent_ord[a]);
                b = a;
                while (b > lo_p && int'(ent_col[b - 1]) > c) begin
                    ent_col[b] = ent_col[b - 1];
                    ent_ord[b] = ent_ord[b - 1];
                    b--;
                end
                ent_col[b] = 8'(c);
                ent_ord[b] = 12'(o);
            end
        end
        is_built = 1;
    endfunction

    function automatic t_rsp predict_csr(t_req q);
        t_rsp r;
        r = '{col: '0, ord: '0, rs: '0, nnz: '0, st: ST_OK};
        case (q.cmd)
            CMD_LOAD: begin
                if (face_cnt >= F_MAX) begin
                    r.st = ST_OVERFLOW;
                end else begin
                    face_up[face_cnt] = q.up;
                    face_lo[face_cnt] = q.lo;
                    face_cnt++;
                    is_built = 0;
                end
            end
            CMD_BUILD: build_csr();
            CMD_READ_ENTRY: begin
                if (!is_built) r.st = ST_NOT_BUILT;
                else if (q.idx >= ent_total || q.idx >= E_MAX) r.st = ST_RANGE;
                else begin
                    r.col = ent_col[q.idx];
                    r.ord = ent_ord[q.idx];
                end
            end
            default: begin
                if (!is_built) r.st = ST_NOT_BUILT;
                else if (q.idx > rows_eff()) r.st = ST_RANGE;
                else r.rs = 12'(row_ptr[q.idx]);
            end
        endcase
        r.nnz = is_built ? 12'(ent_total) : 12'd0;
        return r;
    endfunction

    // Monitor: check results first, then predict for a newly accepted request.
    always @(posedge i_clk) begin
        t_rsp e;
        t_req q;
        s_fire <= i_s_tvalid && o_s_tready;
        if (i_cfg_valid && o_cfg_ready) begin
            row_cfg = int'(i_cfg_data);
            is_built = 0;
            cfg_writes++;
        end
        if (o_m_tvalid && i_m_tready) begin
            if (csr_expect_q.size() == 0) begin
                $error("unexpected result %h", o_m_tdata);
                failed = 1;
            end else begin
                e = csr_expect_q.pop_front();
                if (o_m_tdata[7:0] !== e.col) begin
                    $error("entry_column exp %0d got %0d", e.col, o_m_tdata[7:0]);
                    failed = 1;
                end
                if (o_m_tdata[19:8] !== e.ord) begin
                    $error("entry_ordinal exp %0d got %0d", e.ord, o_m_tdata[19:8]);
                    failed = 1;
                end
                if (o_m_tdata[31:20] !== e.rs) begin
                    $error("row_start exp %0d got %0d", e.rs, o_m_tdata[31:20]);
                    failed = 1;
                end
                if (o_m_tdata[43:32] !== e.nnz) begin
                    $error("nonzero_count exp %0d got %0d", e.nnz, o_m_tdata[43:32]);
                    failed = 1;
                end
                if (o_m_tdata[45:44] !== e.st) begin
                    $error("status exp %0d got %0d", e.st, o_m_tdata[45:44]);
                    failed = 1;
                end
            end
        end
        if (i_s_tvalid && o_s_tready) begin
            q.cmd = t_cmd'(i_s_tuser);
            q.up = i_s_tdata[7:0];
            q.lo = i_s_tdata[15:8];
            q.idx = i_s_tdata[27:16];
            csr_expect_q.insert(csr_expect_q.size(), predict_csr(q));
        end
    end

    // Request driver: bursts of random length with random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        t_req q;
        if (i_rst_n && (!i_s_tvalid || s_fire)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_s_tvalid <= 1'b0;
            end else if (pend_q.size() > 0) begin
                q = pend_q.pop_front();
                i_s_tuser <= q.cmd;
                i_s_tdata <= {4'b0, q.idx, q.lo, q.up};
                i_s_tvalid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: alternating free-running and random stall stretches, plus long holds.
    int  rx_phase = 0;
    int  hold_cnt = 0;
    bit  hold_seen = 0;
    always @(negedge i_clk) begin
        rx_phase <= (rx_phase + 1) % 300;
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_cnt <= 400;
            i_m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_m_tready <= 1'b0;
        end else if (rx_phase < 100) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic add_req(t_cmd c, int u, int l, int x);
        t_req q;
        q.cmd = c;
        q.up = 8'(u);
        q.lo = 8'(l);
        q.idx = 12'(x);
        pend_q.insert(pend_q.size(), q);
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        #1;
        while (pend_q.size() != 0 || i_s_tvalid || csr_expect_q.size() != 0) begin
            @(posedge i_clk);
            #1;
        end
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_rows(int v);
        int seen;
        wait_idle();
        seen = cfg_writes;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= CFG_W'(v);
        while (cfg_writes == seen) begin
            @(posedge i_clk);
            #1;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int rnd_cell(int n);
        if (n == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, 255);
        return $urandom_range(0, n - 1);
    endfunction

    task automatic rand_reads(int n, int cnt, int faces);
        int tot;
        tot = n + 2 * faces;
        for (int k = 0; k < cnt; k++) begin
            case ($urandom_range(0, 9))
                0: add_req(CMD_READ_ENTRY, $urandom, $urandom, $urandom_range(0, 4095));
                1: add_req(CMD_READ_ROW, $urandom, $urandom, $urandom_range(0, 4095));
                2, 3, 4: add_req(CMD_READ_ROW, $urandom, $urandom, $urandom_range(0, n + 1));
                default: add_req(CMD_READ_ENTRY, $urandom, $urandom, $urandom_range(0, tot + 1));
            endcase
        end
    endtask

    task automatic rand_phase(int cfg_val, int rounds, int max_load);
        int n, nl;
        n = (cfg_val > N_MAX) ? N_MAX : cfg_val;
        write_rows(cfg_val);
        for (int rd = 0; rd < rounds; rd++) begin
            nl = $urandom_range(1, max_load);
            for (int k = 0; k < nl; k++)
                add_req(CMD_LOAD, rnd_cell(n), rnd_cell(n), $urandom_range(0, 4095));
            add_req(CMD_BUILD, $urandom, $urandom, $urandom_range(0, 4095));
            rand_reads(n, 8, face_cnt + pend_q.size());
            if ($urandom_range(0, 2) == 0) begin
                add_req(CMD_LOAD, rnd_cell(n), rnd_cell(n), $urandom_range(0, 4095));
                rand_reads(n, 3, 0);
            end
            if (rd == 1) wait_idle();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reads before any build, then a build of the single-row reset setting.
        add_req(CMD_READ_ENTRY, 0, 0, 0);
        add_req(CMD_READ_ROW, 0, 0, 0);
        add_req(CMD_BUILD, 0, 0, 0);
        add_req(CMD_READ_ENTRY, 0, 0, 0);
        add_req(CMD_READ_ROW, 0, 0, 1);
        write_rows(4);
        add_req(CMD_LOAD, 3, 1, 0);
        add_req(CMD_LOAD, 1, 0, 0);
        add_req(CMD_LOAD, 1, 3, 0);
        add_req(CMD_LOAD, 2, 2, 0);
        add_req(CMD_LOAD, 255, 0, 4095);
        add_req(CMD_READ_ENTRY, 0, 0, 0);
        add_req(CMD_BUILD, 255, 255, 4095);
        for (int k = 0; k < 15; k++) add_req(CMD_READ_ENTRY, 0, 0, k);
        add_req(CMD_READ_ENTRY, 255, 255, 4095);
        for (int k = 0; k < 6; k++) add_req(CMD_READ_ROW, 0, 0, k);
        write_rows(0);
        add_req(CMD_BUILD, 0, 0, 0);
        add_req(CMD_READ_ROW, 0, 0, 0);
        add_req(CMD_READ_ROW, 0, 0, 1);
        add_req(CMD_READ_ENTRY, 0, 0, 0);

        for (int p = 0; p < 9; p++)
            rand_phase(cfgs[p], (cfgs[p] > 64) ? 3 : 5, (cfgs[p] > 64) ? 6 : 10);

        // Fill the face store to overflow, with a long result hold while loads stream in.
        write_rows(3);
        for (int k = 0; k < 300; k++)
            add_req(CMD_LOAD, rnd_cell(3), rnd_cell(3), $urandom_range(0, 4095));
        @(negedge i_clk);
        hold_req = ~hold_req;
        while (face_cnt + pend_q.size() < F_MAX + 6)
            add_req(CMD_LOAD, rnd_cell(3), rnd_cell(3), $urandom_range(0, 4095));
        add_req(CMD_BUILD, 0, 0, 0);
        rand_reads(3, 40, F_MAX);
        add_req(CMD_LOAD, 1, 2, 0);
        add_req(CMD_READ_ROW, 0, 0, 2);
        write_rows(2);
        add_req(CMD_BUILD, 0, 0, 0);
        rand_reads(2, 40, F_MAX);

        wait_idle();
        if (!failed && csr_expect_q.size() == 0) begin
            $display("ldu_to_csr_pattern_builder_top_tb OK");
        end else begin
            $display("ldu_to_csr_pattern_builder_top_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("ldu_to_csr_pattern_builder_top_tb NOT OK");
        $finish;
    end

endmodule

// ===== ldu_to_csr_pattern_builder_top.f =====
hw/rtl/ldu_pkg.sv
hw/rtl/ldu_ram.sv
hw/rtl/ldu_to_csr_pattern_builder_top.sv
tb/sv/ldu_to_csr_pattern_builder_top_tb.sv
